// ===== design/alvc_pkg.sv =====
// ----------------------------------------------------------------------------
// alvc_pkg - shared types and microcode for the velocity clamp
// Widths of the datapath, control word layout and the control program ROM.
// ----------------------------------------------------------------------------
package alvc_pkg;

    // field widths
    localparam int COORD_W = 21;
    localparam int SPEED_W = 18;
    localparam int ACCEL_W = 17;
    localparam logic [ACCEL_W-1:0] ACCEL_RESET = 17'd10000;

    // datapath widths: |dx| needs one bit more than a coordinate
    localparam int DIFF_W = COORD_W + 1;
    localparam int MUL_W  = DIFF_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int RAD_W  = PROD_W;
    localparam int ROOT_W = RAD_W / 2;

    // square root iterations, one root bit each
    localparam int SQ_STEPS = ROOT_W;
    localparam int CNT_W    = $clog2(SQ_STEPS);

    // program counter
    localparam int PROG_LEN = 12;
    localparam int PC_W     = $clog2(PROG_LEN);

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DX,
        MUL_DY,
        MUL_VV,
        MUL_AD
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD2
    } acc_op_t;

    typedef enum logic [1:0] {
        JC_NONE,
        JC_NO_INPUT,
        JC_CNT_NZ,
        JC_OUT_BUSY
    } jump_t;

    typedef struct packed {
        mul_sel_t        mul;
        acc_op_t         acc;
        logic            capture;
        logic            sq_init;
        logic            sq_step;
        logic            cnt_load;
        logic            emit;
        jump_t           cond;
        logic [PC_W-1:0] jump;
        logic [PC_W-1:0] next;
    } ctrl_word_t;

    typedef struct packed {
        logic out_busy;
    } dp_stat_t;

    // step labels
    localparam logic [PC_W-1:0] ST_WAIT   = 4'd0;
    localparam logic [PC_W-1:0] ST_MDX    = 4'd1;
    localparam logic [PC_W-1:0] ST_MDY    = 4'd2;
    localparam logic [PC_W-1:0] ST_ADDD   = 4'd3;
    localparam logic [PC_W-1:0] ST_SQ1I   = 4'd4;
    localparam logic [PC_W-1:0] ST_SQ1    = 4'd5;
    localparam logic [PC_W-1:0] ST_MVV    = 4'd6;
    localparam logic [PC_W-1:0] ST_MAD    = 4'd7;
    localparam logic [PC_W-1:0] ST_ADDB   = 4'd8;
    localparam logic [PC_W-1:0] ST_SQ2I   = 4'd9;
    localparam logic [PC_W-1:0] ST_SQ2    = 4'd10;
    localparam logic [PC_W-1:0] ST_EMIT   = 4'd11;

    // control program ROM
    function automatic ctrl_word_t prog_word(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w          = '0;
        w.mul      = MUL_NONE;
        w.acc      = ACC_HOLD;
        w.cond     = JC_NONE;
        w.jump     = ST_WAIT;
        w.next     = ST_WAIT;
        unique case (pc)
            ST_WAIT:
            begin
                w.capture = 1'b1;
                w.cond    = JC_NO_INPUT;
                w.jump    = ST_WAIT;
                w.next    = ST_MDX;
            end
            ST_MDX:
            begin
                w.mul  = MUL_DX;
                w.next = ST_MDY;
            end
            ST_MDY:
            begin
                w.mul  = MUL_DY;
                w.acc  = ACC_LOAD;
                w.next = ST_ADDD;
            end
            ST_ADDD:
            begin
                w.acc  = ACC_ADD;
                w.next = ST_SQ1I;
            end
            ST_SQ1I:
            begin
                w.sq_init  = 1'b1;
                w.cnt_load = 1'b1;
                w.next     = ST_SQ1;
            end
            ST_SQ1:
            begin
                w.sq_step = 1'b1;
                w.cond    = JC_CNT_NZ;
                w.jump    = ST_SQ1;
                w.next    = ST_MVV;
            end
            ST_MVV:
            begin
                w.mul  = MUL_VV;
                w.next = ST_MAD;
            end
            ST_MAD:
            begin
                w.mul  = MUL_AD;
                w.acc  = ACC_LOAD;
                w.next = ST_ADDB;
            end
            ST_ADDB:
            begin
                w.acc  = ACC_ADD2;
                w.next = ST_SQ2I;
            end
            ST_SQ2I:
            begin
                w.sq_init  = 1'b1;
                w.cnt_load = 1'b1;
                w.next     = ST_SQ2;
            end
            ST_SQ2:
            begin
                w.sq_step = 1'b1;
                w.cond    = JC_CNT_NZ;
                w.jump    = ST_SQ2;
                w.next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                w.emit = 1'b1;
                w.cond = JC_OUT_BUSY;
                w.jump = ST_EMIT;
                w.next = ST_WAIT;
            end
            default:
            begin
                w.next = ST_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== design/alvc_sqrt.sv =====
// ----------------------------------------------------------------------------
// alvc_sqrt - iterative floor square root
// Restoring digit recurrence: two radicand bits in, one root bit out per step.
// ----------------------------------------------------------------------------
module alvc_sqrt (
    input  logic                       clk,
    input  logic                       init,
    input  logic                       step,
    input  logic [alvc_pkg::RAD_W-1:0]  radicand,
    output logic [alvc_pkg::ROOT_W-1:0] root
);
    import alvc_pkg::*;

    localparam int REM_W = ROOT_W + 1;
    localparam int TRY_W = REM_W + 2;

    logic [RAD_W-1:0]  n_reg, n_next;
    logic [REM_W-1:0]  r_reg, r_next;
    logic [ROOT_W-1:0] q_reg, q_next;
    logic [TRY_W-1:0]  r_sh;
    logic [TRY_W-1:0]  trial;
    logic [TRY_W-1:0]  diff;

    // one recurrence step
    always_comb
    begin
        r_sh   = {r_reg, n_reg[RAD_W-1 -: 2]};
        trial  = {1'b0, q_reg, 2'b01};
        diff   = r_sh - trial;
        n_next = n_reg;
        r_next = r_reg;
        q_next = q_reg;
        if (init)
        begin
            n_next = radicand;
            r_next = '0;
            q_next = '0;
        end
        else if (step)
        begin
            n_next = {n_reg[RAD_W-3:0], 2'b00};
            if (r_sh >= trial)
            begin
                r_next = diff[REM_W-1:0];
                q_next = {q_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                r_next = r_sh[REM_W-1:0];
                q_next = {q_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        r_reg <= r_next;
        q_reg <= q_next;
    end

    assign root = q_reg;

endmodule

// ===== design/alvc_seq.sv =====
// ----------------------------------------------------------------------------
// alvc_seq - microcode sequencer
// Program counter, iteration counter and conditional jumps over the ROM.
// ----------------------------------------------------------------------------
module alvc_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  alvc_pkg::dp_stat_t   stat,
    output alvc_pkg::ctrl_word_t ctrl
);
    import alvc_pkg::*;

    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             cond_true;

    // fetch and branch
    always_comb
    begin
        ctrl = prog_word(pc_reg);
        unique case (ctrl.cond)
            JC_NONE:     cond_true = 1'b0;
            JC_NO_INPUT: cond_true = !in_valid;
            JC_CNT_NZ:   cond_true = (cnt_reg != '0);
            JC_OUT_BUSY: cond_true = stat.out_busy;
        endcase
        pc_next  = cond_true ? ctrl.jump : ctrl.next;
        cnt_next = cnt_reg;
        if (ctrl.cnt_load)
        begin
            cnt_next = CNT_W'(SQ_STEPS - 1);
        end
        else if (ctrl.cond == JC_CNT_NZ && cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= ST_WAIT;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    // an accepted item always starts the distance products
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.capture && in_valid) |=> (pc_reg == ST_MDX))
        else $error("accepted item did not start the program");

    // the iteration count is live only inside a root loop
    a_cnt_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> ctrl.sq_step)
        else $error("iteration count live outside root loop");

    // program counter stays inside the ROM
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= ST_EMIT)
        else $error("program counter out of range");
`endif

endmodule

// ===== design/alvc_dp.sv =====
// ----------------------------------------------------------------------------
// alvc_dp - datapath of the velocity clamp
// Input capture, path state, shared multiplier, accumulator, root unit and
// the output register, all steered by the control word.
// ----------------------------------------------------------------------------
module alvc_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  alvc_pkg::ctrl_word_t          ctrl,
    input  logic                          in_valid,
    input  logic signed [alvc_pkg::COORD_W-1:0] in_x,
    input  logic signed [alvc_pkg::COORD_W-1:0] in_y,
    input  logic signed [alvc_pkg::SPEED_W-1:0] in_speed,
    input  logic                          in_start,
    input  logic [alvc_pkg::ACCEL_W-1:0]  max_accel,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic signed [alvc_pkg::SPEED_W-1:0] out_speed,
    output logic                          out_clamped,
    output alvc_pkg::dp_stat_t            stat
);
    import alvc_pkg::*;

    // path state
    logic signed [COORD_W-1:0] last_x_reg, last_y_reg;
    logic signed [SPEED_W-1:0] last_speed_reg;
    // per item working registers
    logic [DIFF_W-1:0]         dx_reg, dy_reg;
    logic [SPEED_W-1:0]        vmag_reg;
    logic signed [SPEED_W-1:0] tv_reg;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic [RAD_W-1:0]          acc_reg, acc_next;
    // output register
    logic                      out_valid_reg;
    logic signed [SPEED_W-1:0] out_speed_reg;
    logic                      out_clamped_reg;

    logic                      cap_fire;
    logic                      emit_fire;
    logic signed [COORD_W-1:0] base_x, base_y;
    logic signed [DIFF_W-1:0]  sub_x, sub_y;
    logic [DIFF_W-1:0]         mag_x, mag_y;
    logic signed [SPEED_W-1:0] prev_v;
    logic [SPEED_W-1:0]        prev_mag;
    logic [MUL_W-1:0]          mul_a, mul_b;
    logic [ROOT_W-1:0]         root;
    logic                      clamp;
    logic signed [SPEED_W-1:0] result;

    assign cap_fire      = ctrl.capture && in_valid;
    assign stat.out_busy = out_valid_reg && !out_ready;
    assign emit_fire     = ctrl.emit && !stat.out_busy;

    // distances and previous speed; a path start compares with itself
    always_comb
    begin
        base_x   = in_start ? in_x : last_x_reg;
        base_y   = in_start ? in_y : last_y_reg;
        sub_x    = DIFF_W'(in_x) - DIFF_W'(base_x);
        sub_y    = DIFF_W'(in_y) - DIFF_W'(base_y);
        mag_x    = sub_x[DIFF_W-1] ? (~sub_x + 1'b1) : sub_x;
        mag_y    = sub_y[DIFF_W-1] ? (~sub_y + 1'b1) : sub_y;
        prev_v   = in_start ? in_speed : last_speed_reg;
        prev_mag = prev_v[SPEED_W-1] ? (~prev_v + 1'b1) : prev_v;
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.mul)
            MUL_DX:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            MUL_DY:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            MUL_VV:
            begin
                mul_a = MUL_W'(vmag_reg);
                mul_b = MUL_W'(vmag_reg);
            end
            MUL_AD:
            begin
                mul_a = MUL_W'(max_accel);
                mul_b = MUL_W'(root);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = (ctrl.mul == MUL_NONE) ? prod_reg : (mul_a * mul_b);
    end

    // accumulator
    always_comb
    begin
        unique case (ctrl.acc)
            ACC_HOLD: acc_next = acc_reg;
            ACC_LOAD: acc_next = prod_reg;
            ACC_ADD:  acc_next = acc_reg + prod_reg;
            ACC_ADD2: acc_next = acc_reg + {prod_reg[PROD_W-2:0], 1'b0};
        endcase
    end

    // clamp against the reachable bound
    always_comb
    begin
        clamp  = !tv_reg[SPEED_W-1] && (tv_reg != '0)
                 && (ROOT_W'(tv_reg[SPEED_W-2:0]) > root);
        result = clamp ? $signed(root[SPEED_W-1:0]) : tv_reg;
    end

    alvc_sqrt u_sqrt (
        .clk      (clk),
        .init     (ctrl.sq_init),
        .step     (ctrl.sq_step),
        .radicand (acc_reg),
        .root     (root)
    );

    // working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cap_fire)
        begin
            dx_reg   <= mag_x;
            dy_reg   <= mag_y;
            vmag_reg <= prev_mag;
            tv_reg   <= in_speed;
        end
        if (emit_fire)
        begin
            out_speed_reg   <= result;
            out_clamped_reg <= clamp;
        end
    end

    // path state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            last_speed_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cap_fire)
            begin
                last_x_reg <= in_x;
                last_y_reg <= in_y;
            end
            if (emit_fire)
            begin
                last_speed_reg <= result;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_speed   = out_speed_reg;
    assign out_clamped = out_clamped_reg;

`ifndef SYNTHESIS
    // a clamped speed lies strictly below its target
    a_clamp_below: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> (!out_clamped_reg || (out_speed_reg < $past(tv_reg))))
        else $error("clamped speed not below target");

    // a new result appears only from the emit step
    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(emit_fire))
        else $error("result valid without emit");

    // no input is taken in the emit step
    a_emit_no_capture: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> !ctrl.capture)
        else $error("emit and capture in one step");
`endif

endmodule

// ===== design/accel_limited_velocity_clamp.sv =====
// ----------------------------------------------------------------------------
// accel_limited_velocity_clamp - forward acceleration limit on path speeds
// Clamps each path point's target speed to what is reachable from the
// previous point under the configured acceleration.
// ----------------------------------------------------------------------------
// Usage:
//   Path points enter on the s_* stream, one result leaves on m_* for each
//   point, in order. path_start in s_tuser opens a new path; that point
//   passes unchanged. The cfg channel writes max_accel (always ready); write
//   it only while no point is in flight.
// Sequence and rate:
//   One point at a time through a microcoded sequencer. A point passes
//   through capture, the distance products, the distance root, the bound
//   products, the bound root and the load of the output register. Both
//   roots run on one root unit at one bit per cycle.
//   The next point is accepted in the cycle after the result is loaded.
// Reset:
//   Previous point is (0,0) at speed 0, max_accel is 10000 mm/s^2.
// Stall:
//   The result waits in the output register; a new point may be taken and
//   computed meanwhile, and the sequencer holds in its emit step until the
//   register is free.
// ----------------------------------------------------------------------------
module accel_limited_velocity_clamp (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // point_x[20:0], point_y[41:21], target_speed[59:42]
    input  logic        s_tuser,   // path_start[0]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // limited_speed[17:0]
    output logic        m_tuser,   // was_clamped[0]
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data   // max_accel[16:0]
);
    import alvc_pkg::*;

    logic [ACCEL_W-1:0]        max_accel_reg;
    ctrl_word_t                ctrl;
    dp_stat_t                  stat;
    logic signed [SPEED_W-1:0] out_speed;
    logic                      out_clamped;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_accel_reg <= ACCEL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_accel_reg <= cfg_data;
        end
    end

    assign s_tready = ctrl.capture;

    alvc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    alvc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .in_valid    (s_tvalid),
        .in_x        (s_tdata[20:0]),
        .in_y        (s_tdata[41:21]),
        .in_speed    (s_tdata[59:42]),
        .in_start    (s_tuser),
        .max_accel   (max_accel_reg),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_speed   (out_speed),
        .out_clamped (out_clamped),
        .stat        (stat)
    );

    // output packing
    assign m_tdata = {6'b0, out_speed};
    assign m_tuser = out_clamped;

endmodule
